/* sv/glob_wildcard_matcher_macros.svh */
// Assertion macros used by the glob wildcard matcher checker.
`ifndef GLOB_WILDCARD_MATCHER_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GWM_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GWM_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/gwm_pkg.sv */
// Shared types, codes and character helpers for the glob wildcard matcher.
package gwm_pkg;

   localparam int MASK_MAX_DEF  = 32;
   localparam int CHAR_BITS_DEF = 16;
   localparam int CHAR_CODE_W   = 16;
   localparam int REQ_TYPE_W    = 2;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_MASK = 2'd0,
      REQ_NAME = 2'd1,
      REQ_END  = 2'd2
   } req_kind_type;

   localparam logic [CHAR_CODE_W-1:0] CH_ANY_ONE = 16'h003F;
   localparam logic [CHAR_CODE_W-1:0] CH_ANY_RUN = 16'h002A;
   localparam logic [CHAR_CODE_W-1:0] CH_LOW_A   = 16'h0061;
   localparam logic [CHAR_CODE_W-1:0] CH_LOW_Z   = 16'h007A;
   localparam logic [CHAR_CODE_W-1:0] CH_UP_A    = 16'h0041;

   // Fold ASCII a-z onto A-Z when folding is enabled.
   function automatic logic [CHAR_CODE_W-1:0] fold_char(input logic [CHAR_CODE_W-1:0] c,
                                                        input logic fold);
      logic [CHAR_CODE_W-1:0] r;
      r = c;
      if (fold && c >= CH_LOW_A && c <= CH_LOW_Z) begin
         r = c - CH_LOW_A + CH_UP_A;
      end
      return r;
   endfunction

endpackage

/* sv/glob_wildcard_matcher.sv */
// Top level: glob mask store and bit-parallel live-position matcher.
// Flow: an accepted transaction is held in the input register stage, then processed;
//   an end-of-name result goes to the result register that drives rsp_*.
// Throughput: one transaction per cycle unless an end-of-name stalls on rsp_ready;
//   star closure is a combinational log-depth prefix network over MASK_MAX+1 bits.
// Reset (synchronous, active high): empty mask, start position live, fold_case off,
//   pipeline and result register empty. The mask store itself is not cleared.
module glob_wildcard_matcher #(
   parameter int MASK_MAX  = gwm_pkg::MASK_MAX_DEF,
   parameter int CHAR_BITS = gwm_pkg::CHAR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gwm_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [gwm_pkg::CHAR_CODE_W-1:0]    req_char_code,
   input  logic                               req_mask_first,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_matched,
   output logic                               rsp_mask_too_long,
   // control register write
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_fold_case
);

   localparam int CodeW  = gwm_pkg::CHAR_CODE_W;
   localparam int PosW   = MASK_MAX + 1;
   localparam int CountW = $clog2(MASK_MAX + 1);
   localparam int IdxW   = $clog2(MASK_MAX);
   localparam int Levels = $clog2(PosW);

   // ---------------------------------------------------------------------------
   // Input register stage
   // ---------------------------------------------------------------------------
   logic                          s1_valid_ff, s1_valid_in;
   logic [gwm_pkg::REQ_TYPE_W-1:0] s1_type_ff;
   logic [CHAR_BITS-1:0]          s1_char_ff;
   logic                          s1_first_ff;
   logic                          s1_fire;
   logic                          req_fire;

   // ---------------------------------------------------------------------------
   // Matcher state
   // ---------------------------------------------------------------------------
   logic [CHAR_BITS-1:0] store_ff [MASK_MAX];
   logic                 store_we;
   logic [IdxW-1:0]      store_idx;
   logic [CountW-1:0]    count_ff, count_in;
   logic                 overflow_ff, overflow_in;
   // Live positions are held before star closure; closure is applied on read,
   // so a freshly written mask never needs a second pass to rearm.
   logic [PosW-1:0]      raw_ff, raw_in;
   logic                 fold_ff, fold_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 matched_ff, matched_in;
   logic                 too_long_ff, too_long_in;

   // Per-position decode of the stored mask
   logic [MASK_MAX-1:0]  in_mask;
   logic [MASK_MAX-1:0]  star_vec;
   logic [MASK_MAX-1:0]  step_vec;
   logic [PosW-1:0]      live_eff;
   logic [PosW-1:0]      live_nxt;
   logic [CodeW-1:0]     name_folded;
   logic                 end_hit;
   logic [CountW-1:0]    base_count;

   // Handshakes: the input stage drains whenever its transaction has somewhere to go;
   // only an end-of-name needs the result register to be free.
   assign s1_fire   = s1_valid_ff &&
                      ((s1_type_ff != gwm_pkg::REQ_END) || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Decode stored characters against the name character held in the input stage.
   always_comb begin
      name_folded = gwm_pkg::fold_char(CodeW'(s1_char_ff), fold_ff);
      for (int i = 0; i < MASK_MAX; i++) begin
         in_mask[i]  = CountW'(i) < count_ff;
         star_vec[i] = in_mask[i] && (CodeW'(store_ff[i]) == gwm_pkg::CH_ANY_RUN);
         // A non-star position steps forward on '?' or on an equal character.
         step_vec[i] = in_mask[i] && !star_vec[i] &&
                       ((CodeW'(store_ff[i]) == gwm_pkg::CH_ANY_ONE) ||
                        (gwm_pkg::fold_char(CodeW'(store_ff[i]), fold_ff) == name_folded));
      end
   end

   // Star closure as a parallel prefix: a live position propagates through any
   // run of stars that follows it. Descending index keeps lower bits from the
   // previous level.
   always_comb begin
      logic [PosW-1:0] g;
      logic [PosW-1:0] p;
      int              d;
      g = raw_ff;
      p = '0;
      for (int i = 1; i < PosW; i++) begin
         p[i] = star_vec[i-1];
      end
      for (int lvl = 0; lvl < Levels; lvl++) begin
         d = 1 << lvl;
         for (int i = PosW - 1; i >= d; i--) begin
            g[i] = g[i] | (p[i] & g[i-d]);
            p[i] = p[i] & p[i-d];
         end
      end
      live_eff = g;
   end

   // Advance the live vector by one name character.
   always_comb begin
      live_nxt = '0;
      for (int i = 0; i < MASK_MAX; i++) begin
         if (live_eff[i] && star_vec[i]) begin
            live_nxt[i] = 1'b1;
         end
         if (live_eff[i] && step_vec[i]) begin
            live_nxt[i+1] = 1'b1;
         end
      end
   end

   assign end_hit    = live_eff[count_ff] && !overflow_ff;
   assign base_count = s1_first_ff ? '0 : count_ff;

   // Next-state logic
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      raw_in       = raw_ff;
      fold_in      = fold_ff;
      rsp_valid_in = rsp_valid_ff;
      matched_in   = matched_ff;
      too_long_in  = too_long_ff;
      store_we     = 1'b0;
      store_idx    = base_count[IdxW-1:0];

      if (csr_valid && csr_ready) begin
         fold_in = csr_fold_case;
      end

      // drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_fire) begin
         s1_valid_in = 1'b0;
         case (s1_type_ff)
            gwm_pkg::REQ_MASK: begin
               // a new mask restarts count and overflow before storing
               overflow_in = s1_first_ff ? 1'b0 : overflow_ff;
               count_in    = base_count;
               if (base_count < CountW'(MASK_MAX)) begin
                  store_we = 1'b1;
                  count_in = base_count + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               raw_in = PosW'(1);
            end
            gwm_pkg::REQ_NAME: begin
               raw_in = live_nxt;
            end
            gwm_pkg::REQ_END: begin
               rsp_valid_in = 1'b1;
               matched_in   = end_hit;
               too_long_in  = overflow_ff;
               raw_in       = PosW'(1);
            end
            default: begin
               // unused request code: no effect
            end
         endcase
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         raw_ff       <= PosW'(1);
         fold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         raw_ff       <= raw_in;
         fold_ff      <= fold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: input stage capture and result fields
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff  <= req_type;
         s1_char_ff  <= req_char_code[CHAR_BITS-1:0];
         s1_first_ff <= req_mask_first;
      end
      matched_ff  <= matched_in;
      too_long_ff <= too_long_in;
   end

   // Mask store: one write port at the fill position
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_idx] <= s1_char_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_matched       = matched_ff;
   assign rsp_mask_too_long = too_long_ff;

endmodule

/* sv/gwm_checker.sv */
// Port-level checker for the glob wildcard matcher, bound to the top level.
`include "glob_wildcard_matcher_macros.svh"

module gwm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [gwm_pkg::REQ_TYPE_W-1:0] req_type,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_matched,
   input logic                           rsp_mask_too_long
);

   // a stalled result holds its fields
   `GWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_matched) && $stable(rsp_mask_too_long), "rsp changed while stalled")

   // an overlong mask never matches
   `GWM_ASSERT_NOW(a_too_long_no_match, clock, reset, rsp_valid && rsp_mask_too_long, !rsp_matched, "match reported on overlong mask")

   // a fresh result comes only from an accepted end-of-name, via the input stage and result register
   `GWM_ASSERT_NOW(a_rsp_from_end, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && (req_type == gwm_pkg::REQ_END), 2), "result without end-of-name")

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (.*);

/* bench/gwm_tb_pkg.sv */
// Glob verdict predictor and result checker used by the matcher bench.
package gwm_tb_pkg;
   import gwm_pkg::*;

   localparam int PATTERN_MAX = MASK_MAX_DEF;
   // Only the start position live.
   localparam bit [PATTERN_MAX:0] START_LIVE = {{PATTERN_MAX{1'b0}}, 1'b1};

   typedef struct packed {
      logic matched;
      logic too_long;
   } verdict_t;

   class glob_verdicts;
      bit                     fold;
      logic [CHAR_CODE_W-1:0] pattern [PATTERN_MAX];
      int unsigned            pat_len;
      bit [PATTERN_MAX:0]     live;
      bit                     overflowed;
      verdict_t               pending [$];
      int unsigned            failures;
      int unsigned            checked;
      int unsigned            hits;
      int unsigned            overflows;

      function new();
         fold       = 1'b0;
         pat_len    = 0;
         overflowed = 1'b0;
         live       = START_LIVE;
      endfunction

      function logic [CHAR_CODE_W-1:0] folded(logic [CHAR_CODE_W-1:0] c);
         folded = c;
         if (fold && c >= CH_LOW_A && c <= CH_LOW_Z) begin
            folded = c - (CH_LOW_A - CH_UP_A);
         end
      endfunction

      // A live star also makes the position after it live (empty run).
      function bit [PATTERN_MAX:0] close_stars(bit [PATTERN_MAX:0] v);
         for (int i = 0; i < pat_len; i++) begin
            if (v[i] && pattern[i] == CH_ANY_RUN) begin
               v[i+1] = 1'b1;
            end
         end
         return v;
      endfunction

      function void apply_request(logic [REQ_TYPE_W-1:0] kind,
                                  logic [CHAR_CODE_W-1:0] c, logic first);
         bit [PATTERN_MAX:0] nxt;
         verdict_t           v;
         case (kind)
            REQ_MASK: begin
               if (first) begin
                  pat_len    = 0;
                  overflowed = 1'b0;
               end
               if (pat_len < PATTERN_MAX) begin
                  pattern[pat_len] = c;
                  pat_len++;
               end else begin
                  overflowed = 1'b1;
               end
               live = close_stars(START_LIVE);
            end
            REQ_NAME: begin
               nxt = '0;
               for (int i = 0; i < pat_len; i++) begin
                  if (live[i]) begin
                     if (pattern[i] == CH_ANY_RUN) begin
                        nxt[i] = 1'b1;
                     end else if (pattern[i] == CH_ANY_ONE ||
                                  folded(pattern[i]) == folded(c)) begin
                        nxt[i+1] = 1'b1;
                     end
                  end
               end
               live = close_stars(nxt);
            end
            REQ_END: begin
               v.matched  = live[pat_len] && !overflowed;
               v.too_long = overflowed;
               pending.push_back(v);
               live = close_stars(START_LIVE);
            end
            default: ;
         endcase
      endfunction

      function void compare_verdict(logic matched, logic too_long, time stamp);
         verdict_t want;
         if (pending.size() == 0) begin
            $display("%0t: result with nothing pending: expected none, got matched=%0b mask_too_long=%0b",
                     stamp, matched, too_long);
            failures++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.matched) hits++;
         if (want.too_long) overflows++;
         if (matched !== want.matched) begin
            $display("%0t: matched mismatch: expected %0b, got %0b",
                     stamp, want.matched, matched);
            failures++;
         end
         if (too_long !== want.too_long) begin
            $display("%0t: mask_too_long mismatch: expected %0b, got %0b",
                     stamp, want.too_long, too_long);
            failures++;
         end
      endfunction
   endclass

endpackage

/* bench/testbench.sv */
// Self-checking bench for the glob wildcard matcher: directed cases, then random sessions.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gwm_pkg::*;
   import gwm_tb_pkg::*;

   // Cycles with no transaction on any channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 2000;
   // Length of the long receiver hold-off that fills the block.
   localparam int HOLDOFF_CYCLES = 300;
   // Extra drain wait once no verdict is pending, for the input stage and result register.
   localparam int SETTLE_CYCLES  = 4;
   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [CHAR_CODE_W-1:0] req_char_code;
   logic                   req_mask_first;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_matched;
   logic                   rsp_mask_too_long;
   logic                   csr_valid;
   logic                   csr_ready;
   logic                   csr_fold_case;

   glob_verdicts verdicts = new();

   int          send_idle_pct;
   int          rsp_stall_pct;
   bit          holdoff_req;
   int unsigned items_sent;
   int unsigned idle_run;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   glob_wildcard_matcher DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_mask_first    (req_mask_first),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_mask_too_long (rsp_mask_too_long),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_fold_case     (csr_fold_case)
   );

   // Receiver: drive ready at the falling edge. On request, hold ready low for a
   // long stretch counted here, so the sender keeps offering and the block backs up.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            holdoff_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Check every accepted result transaction against the oldest pending verdict.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         verdicts.compare_verdict(rsp_matched, rsp_mask_too_long, $time);
      end
   end

   // Watchdog: abandon the run once no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_run = 0;
      end else begin
         idle_run++;
      end
      if (idle_run >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[glob_wildcard_matcher] ERROR");
         $finish;
      end
   end

   // Offer one request transaction; enter and leave at a falling edge.
   // Insert random gaps first, then hold valid and payload until accepted.
   task automatic offer(logic [REQ_TYPE_W-1:0] kind, logic [CHAR_CODE_W-1:0] c,
                        logic first);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_char_code  <= c;
      req_mask_first <= first;
      do @(posedge clock); while (!req_ready);
      verdicts.apply_request(kind, c, first);
      if (kind != REQ_UNUSED) items_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every pending verdict, then let the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      while (verdicts.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the case-folding register; only ever called with the block idle.
   task automatic write_fold(bit v);
      csr_valid     <= 1'b1;
      csr_fold_case <= v;
      do @(posedge clock); while (!csr_ready);
      verdicts.fold = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Characters biased towards a few letters so that names actually match,
   // with wildcards, codes around the a-z and A-Z borders, zero and full range.
   function automatic logic [CHAR_CODE_W-1:0] pick_char(bit wild);
      logic [CHAR_CODE_W-1:0] fringe [8];
      fringe = '{16'h0000, 16'hFFFF, CH_UP_A - 16'd1, CH_UP_A + 16'd26,
                 CH_LOW_A - 16'd1, CH_LOW_Z + 16'd1, CH_ANY_RUN, CH_ANY_ONE};
      case ($urandom_range(0, 11))
         0, 1, 2: return CH_LOW_A + CHAR_CODE_W'($urandom_range(0, 2));
         3, 4:    return CH_UP_A + CHAR_CODE_W'($urandom_range(0, 2));
         5:       return wild ? CH_ANY_RUN : CH_LOW_A + CHAR_CODE_W'($urandom_range(0, 25));
         6:       return wild ? CH_ANY_ONE : CH_UP_A + CHAR_CODE_W'($urandom_range(0, 25));
         7, 8:    return CHAR_CODE_W'($urandom_range(0, 16'hFFFF));
         9:       return fringe[$urandom_range(0, 7)];
         default: return CHAR_CODE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly short masks; now and then one that fills or overruns the store.
   function automatic int pick_mask_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return $urandom_range(MASK_MAX_DEF + 1, MASK_MAX_DEF + 8);
      if (r < 6) return MASK_MAX_DEF;
      if (r < 15) return 1;
      return $urandom_range(2, 8);
   endfunction

   // One session: load a mask, then stream a few names against it. Most names
   // are built from the mask (runs for stars, any character for '?', letters
   // sometimes case-swapped), some of those get one character spoilt, the rest
   // are random. A little noise: unused requests and mask characters mid-name.
   task automatic run_mask_session(int mask_len);
      logic [CHAR_CODE_W-1:0] mask_chars [$];
      logic [CHAR_CODE_W-1:0] name_chars [$];
      logic [CHAR_CODE_W-1:0] c;
      for (int i = 0; i < mask_len; i++) begin
         c = pick_char(1'b1);
         offer(REQ_MASK, c, i == 0);
         mask_chars.push_back(c);
      end
      repeat ($urandom_range(1, 4)) begin
         name_chars.delete();
         if ($urandom_range(0, 99) < 70) begin
            foreach (mask_chars[i]) begin
               c = mask_chars[i];
               if (c == CH_ANY_RUN) begin
                  repeat ($urandom_range(0, 3)) name_chars.push_back(pick_char(1'b0));
               end else if (c == CH_ANY_ONE) begin
                  name_chars.push_back(pick_char(1'b0));
               end else begin
                  if ($urandom_range(0, 9) < 3) begin
                     if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
                        c = c - (CH_LOW_A - CH_UP_A);
                     end else if (c >= CH_UP_A && c <= CH_UP_A + 16'd25) begin
                        c = c + (CH_LOW_A - CH_UP_A);
                     end
                  end
                  name_chars.push_back(c);
               end
            end
            if ($urandom_range(0, 99) < 15 && name_chars.size() > 0) begin
               name_chars[$urandom_range(0, name_chars.size() - 1)] = pick_char(1'b0);
            end
         end else begin
            repeat ($urandom_range(0, 6)) name_chars.push_back(pick_char(1'b0));
         end
         foreach (name_chars[i]) begin
            if ($urandom_range(0, 99) < 2) begin
               offer(REQ_UNUSED, CHAR_CODE_W'($urandom_range(0, 16'hFFFF)),
                     1'($urandom_range(0, 1)));
            end else if ($urandom_range(0, 99) < 2) begin
               // A mask character here restarts the name inside the block.
               c = pick_char(1'b1);
               offer(REQ_MASK, c, 1'b0);
               mask_chars.push_back(c);
            end
            offer(REQ_NAME, name_chars[i], 1'($urandom_range(0, 1)));
         end
         offer(REQ_END, CHAR_CODE_W'($urandom_range(0, 16'hFFFF)),
               1'($urandom_range(0, 1)));
      end
   endtask

   // One phase: drain, set folding, sender idling, receiver stalls and hold-off, then run sessions to a quota.
   task automatic run_phase(bit fold, int idle_pct, int stall_pct, int unsigned quota,
                            bit with_holdoff, int first_len);
      int unsigned start;
      settle();
      write_fold(fold);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (with_holdoff) holdoff_req = 1'b1;
      start = items_sent;
      if (first_len > 0) run_mask_session(first_len);
      while (items_sent - start < quota) run_mask_session(pick_mask_len());
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_MASK;
      req_char_code  = '0;
      req_mask_first = 1'b0;
      csr_valid      = 1'b0;
      csr_fold_case  = 1'b0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      holdoff_req    = 1'b0;
      items_sent     = 0;
      idle_run       = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty mask after reset: the empty name matches, a one-letter name does not.
      offer(REQ_END, '0, 1'b0);
      offer(REQ_NAME, CH_LOW_A, 1'b0);
      offer(REQ_END, '0, 1'b0);
      // "a*?" against "ab", then against "Ab" with folding off.
      offer(REQ_MASK, CH_LOW_A, 1'b1);
      offer(REQ_MASK, CH_ANY_RUN, 1'b0);
      offer(REQ_MASK, CH_ANY_ONE, 1'b0);
      offer(REQ_NAME, CH_LOW_A, 1'b0);
      offer(REQ_NAME, CH_LOW_A + 16'd1, 1'b0);
      offer(REQ_END, '0, 1'b0);
      offer(REQ_NAME, CH_UP_A, 1'b0);
      offer(REQ_NAME, CH_LOW_A + 16'd1, 1'b0);
      offer(REQ_END, '0, 1'b0);
      // Zero code is an ordinary character.
      offer(REQ_MASK, 16'h0000, 1'b1);
      offer(REQ_NAME, 16'h0000, 1'b0);
      offer(REQ_END, 16'hFFFF, 1'b1);
      // Top code, a trailing star and an unused request that must be ignored.
      offer(REQ_MASK, 16'hFFFF, 1'b1);
      offer(REQ_MASK, CH_ANY_RUN, 1'b0);
      offer(REQ_NAME, 16'hFFFF, 1'b0);
      offer(REQ_UNUSED, 16'hFFFF, 1'b1);
      offer(REQ_END, '0, 1'b0);
      // Extend the mask mid-name; the name starts over.
      offer(REQ_NAME, 16'hFFFF, 1'b0);
      offer(REQ_MASK, CH_LOW_A + 16'd23, 1'b0);
      offer(REQ_NAME, 16'hFFFF, 1'b0);
      offer(REQ_NAME, CH_LOW_A + 16'd23, 1'b0);
      offer(REQ_END, '0, 1'b0);

      // Folding on: letters match across case, neighbours of the ranges do not.
      settle();
      write_fold(1'b1);
      offer(REQ_MASK, CH_LOW_A, 1'b1);
      offer(REQ_MASK, CH_UP_A + 16'd25, 1'b0);
      offer(REQ_NAME, CH_UP_A, 1'b0);
      offer(REQ_NAME, CH_LOW_Z, 1'b0);
      offer(REQ_END, '0, 1'b0);
      offer(REQ_MASK, CH_LOW_A - 16'd1, 1'b1);
      offer(REQ_NAME, CH_UP_A - 16'd1, 1'b0);
      offer(REQ_END, '0, 1'b0);

      // Random phases: full rate, sender gaps, receiver stalls with one long
      // hold-off, both lightly, then full rate again. Some open on a mask that
      // fills or overruns the store.
      run_phase(1'b1, 0, 0, 250, 1'b0, MASK_MAX_DEF);
      run_phase(1'b0, 58, 0, 230, 1'b0, MASK_MAX_DEF + 4);
      run_phase(1'b1, 0, 58, 230, 1'b1, 0);
      run_phase(1'b0, 19, 19, 230, 1'b0, MASK_MAX_DEF + 8);
      run_phase(1'b1, 0, 0, 200, 1'b0, 0);
      settle();

      $display("Sent %0d requests through five random phases plus directed cases, folding off and on.",
               items_sent);
      $display("Checked %0d name results: %0d matches, %0d from over-long masks.",
               verdicts.checked, verdicts.hits, verdicts.overflows);
      if (verdicts.failures == 0 && verdicts.pending.size() == 0) begin
         $display("[glob_wildcard_matcher] OK");
      end else begin
         $display("[glob_wildcard_matcher] ERROR");
      end
      $finish;
   end

endmodule

/* glob_wildcard_matcher.f */
+incdir+sv
sv/gwm_pkg.sv
sv/glob_wildcard_matcher.sv
sv/gwm_checker.sv
bench/gwm_tb_pkg.sv
bench/testbench.sv
